/* rtl/pfc_pkg.sv */
// Package for the packet framer with CRC-16/CCITT-FALSE.
// Holds the item and result types, the byte-position codes, the framing
// constants and the byte-wise CRC function. No dependencies.
package pfc_pkg;

  // Item kinds carried in tuser of the input channel.
  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Framing constants.
  localparam logic [7:0]  SOF_FIRST  = 8'hAA;
  localparam logic [7:0]  SOF_SECOND = 8'h55;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  // Position of the next byte within the packet being emitted.
  typedef enum logic [3:0] {
    POS_START,
    POS_SOF1,
    POS_VER,
    POS_TYPE,
    POS_FLAGS,
    POS_SEQ,
    POS_LEN_LO,
    POS_LEN_HI,
    POS_CRC_LO,
    POS_CRC_HI
  } pfc_pos_t;

  // One input item.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [7:0]  flag_bits;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;
  } pfc_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_packet;
    logic       error;
  } pfc_res_t;

  // Feed one byte into a CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/pfc_core.sv */
// Framing sequencer: packet state, byte position, sequence number and CRC.
// Produces one result per step from the held input item.
// Depends on pfc_pkg.
module pfc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  pfc_pkg::pfc_item_t item,
  output pfc_pkg::pfc_res_t  res
);

  pfc_pkg::pfc_pos_t pos_r, pos_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        open_r, open_nxt;

  logic        is_hdr;
  logic        err;
  logic [15:0] crc_in;
  logic [15:0] crc_fed;

  assign is_hdr = (item.cmd == pfc_pkg::CMD_HEADER);

  // An item out of sequence is rejected on its first step.
  assign err = (pos_r == pfc_pkg::POS_START) && (is_hdr ? open_r : !open_r);

  // The header CRC starts fresh at the version byte.
  assign crc_in  = (pos_r == pfc_pkg::POS_VER) ? pfc_pkg::CRC_INIT : crc_r;
  assign crc_fed = pfc_pkg::crc16_feed(crc_in, res.out_byte);

  // Result byte and flags for the current position.
  always_comb begin
    res = '0;
    if (err) begin
      res.error       = 1'b1;
      res.last_of_run = 1'b1;
    end else begin
      case (pos_r)
        pfc_pkg::POS_START: begin
          if (is_hdr) begin
            res.out_byte = pfc_pkg::SOF_FIRST;
          end else begin
            res.out_byte    = item.data_byte;
            res.last_of_run = (rem_r != 16'd1);
          end
        end
        pfc_pkg::POS_SOF1:   res.out_byte = pfc_pkg::SOF_SECOND;
        pfc_pkg::POS_VER:    res.out_byte = item.version;
        pfc_pkg::POS_TYPE:   res.out_byte = item.msg_type;
        pfc_pkg::POS_FLAGS:  res.out_byte = item.flag_bits;
        pfc_pkg::POS_SEQ:    res.out_byte = seq_r;
        pfc_pkg::POS_LEN_LO: res.out_byte = item.payload_len[7:0];
        pfc_pkg::POS_LEN_HI: begin
          res.out_byte    = item.payload_len[15:8];
          res.last_of_run = (item.payload_len != 16'd0);
        end
        pfc_pkg::POS_CRC_LO: res.out_byte = crc_r[7:0];
        pfc_pkg::POS_CRC_HI: begin
          res.out_byte      = crc_r[15:8];
          res.end_of_packet = 1'b1;
          res.last_of_run   = 1'b1;
        end
        default: res = '0;
      endcase
    end
  end

  // Next position and packet state.
  always_comb begin
    pos_nxt  = pos_r;
    seq_nxt  = seq_r;
    crc_nxt  = crc_r;
    rem_nxt  = rem_r;
    open_nxt = open_r;
    if (step && !err) begin
      case (pos_r)
        pfc_pkg::POS_START: begin
          if (is_hdr) begin
            pos_nxt = pfc_pkg::POS_SOF1;
          end else begin
            crc_nxt = crc_fed;
            rem_nxt = rem_r - 16'd1;
            pos_nxt = (rem_r == 16'd1) ? pfc_pkg::POS_CRC_LO : pfc_pkg::POS_START;
          end
        end
        pfc_pkg::POS_SOF1: pos_nxt = pfc_pkg::POS_VER;
        pfc_pkg::POS_VER: begin
          crc_nxt = crc_fed;
          pos_nxt = pfc_pkg::POS_TYPE;
        end
        pfc_pkg::POS_TYPE: begin
          crc_nxt = crc_fed;
          pos_nxt = pfc_pkg::POS_FLAGS;
        end
        pfc_pkg::POS_FLAGS: begin
          crc_nxt = crc_fed;
          pos_nxt = pfc_pkg::POS_SEQ;
        end
        pfc_pkg::POS_SEQ: begin
          crc_nxt = crc_fed;
          seq_nxt = seq_r + 8'd1;
          pos_nxt = pfc_pkg::POS_LEN_LO;
        end
        pfc_pkg::POS_LEN_LO: begin
          crc_nxt = crc_fed;
          pos_nxt = pfc_pkg::POS_LEN_HI;
        end
        pfc_pkg::POS_LEN_HI: begin
          crc_nxt = crc_fed;
          if (item.payload_len != 16'd0) begin
            open_nxt = 1'b1;
            rem_nxt  = item.payload_len;
            pos_nxt  = pfc_pkg::POS_START;
          end else begin
            pos_nxt = pfc_pkg::POS_CRC_LO;
          end
        end
        pfc_pkg::POS_CRC_LO: pos_nxt = pfc_pkg::POS_CRC_HI;
        pfc_pkg::POS_CRC_HI: begin
          crc_nxt  = pfc_pkg::CRC_INIT;
          open_nxt = 1'b0;
          rem_nxt  = '0;
          pos_nxt  = pfc_pkg::POS_START;
        end
        default: pos_nxt = pfc_pkg::POS_START;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= pfc_pkg::POS_START;
      seq_r  <= '0;
      crc_r  <= pfc_pkg::CRC_INIT;
      rem_r  <= '0;
      open_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      seq_r  <= seq_nxt;
      crc_r  <= crc_nxt;
      rem_r  <= rem_nxt;
      open_r <= open_nxt;
    end
  end

  // An open packet waiting for its next item always owes at least one payload byte.
  a_open_owes: assert property (@(posedge clk) disable iff (!rst_n)
    (open_r && (pos_r == pfc_pkg::POS_START)) |-> (rem_r != 16'd0))
    else $error("packet open with no payload owed");

  // The end of a packet also ends the item's results.
  a_eop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.end_of_packet) |-> res.last_of_run)
    else $error("end of packet without last of run");

  // After an item's final result the sequencer is back at the start.
  a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.last_of_run) |=> (pos_r == pfc_pkg::POS_START))
    else $error("sequencer not at start after final result");

  // A rejected item leaves the packet state untouched.
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.error) |=> ($stable(seq_r) && $stable(crc_r) && $stable(rem_r)
                             && $stable(open_r)))
    else $error("error result changed packet state");

endmodule

/* rtl/packet_framer_crc16.sv */
// Packet framer with CRC-16/CCITT-FALSE. The first result is registered in the output
// register from the item held in the input register. Payload items run at one per cycle
// while the output is not stalled, the last one of a packet also emitting both CRC bytes;
// a header emits both SOF bytes, version, type, flags, sequence and both length bytes,
// and both CRC bytes with zero length; the one-byte-per-cycle output register sets this.
// Reset clears both channels, the sequence number and packet state, and loads CRC_INIT.
module packet_framer_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // version[7:0], msg_type[15:8], flag_bits[23:16], payload_len[39:24], data_byte[47:40]
  input  logic [47:0] in_tdata,
  // cmd[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // end_of_packet[0], error[1]
  output logic [1:0]  out_tuser
);

  pfc_pkg::pfc_item_t item_r, item_nxt;
  logic               item_vld_r, item_vld_nxt;
  pfc_pkg::pfc_res_t  res;
  pfc_pkg::pfc_res_t  res_r, res_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic               step;
  logic               in_take;

  // The sequencer advances whenever an item is held and the output register can take a byte.
  assign step      = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || (step && res.last_of_run);
  assign in_take   = in_tvalid && in_tready;

  // Input register.
  always_comb begin
    item_nxt     = item_r;
    item_vld_nxt = item_vld_r;
    if (in_take) begin
      item_nxt.cmd         = in_tuser;
      item_nxt.version     = in_tdata[7:0];
      item_nxt.msg_type    = in_tdata[15:8];
      item_nxt.flag_bits   = in_tdata[23:16];
      item_nxt.payload_len = in_tdata[39:24];
      item_nxt.data_byte   = in_tdata[47:40];
      item_vld_nxt         = 1'b1;
    end else if (step && res.last_of_run) begin
      item_vld_nxt = 1'b0;
    end
  end

  // Output register.
  always_comb begin
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (step) begin
      res_nxt     = res;
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  pfc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .res   (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r.out_byte;
  assign out_tlast  = res_r.last_of_run;
  assign out_tuser  = {res_r.error, res_r.end_of_packet};

  // A result waiting on the output is never overwritten.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !step)
    else $error("output overwritten while stalled");

  // An error result carries a zero byte and ends its run.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.error) |-> (out_tlast && (res_r.out_byte == 8'd0)))
    else $error("malformed error result");

  // A new item is only taken into an empty or draining input register.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && item_vld_r) |-> (step && res.last_of_run))
    else $error("input register overwritten");

endmodule
